// ----- hw/rtl/gpio_register_block_top_assert.svh -----
// ----------------------------------------------------------------------------
// GPIO register block assertion macros
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef GPIO_REGISTER_BLOCK_TOP_ASSERT_SVH
`define GPIO_REGISTER_BLOCK_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// check held off while reset is high
`define GRB_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
// check that also runs through reset
`define GRB_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");
`else
`define GRB_ASSERT(lbl, clk, rst, prop)
`define GRB_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ----- hw/rtl/gpio_rb_pkg.sv -----
// ----------------------------------------------------------------------------
// GPIO register block package
// Sizes, group and access codes, and the request/response item types.
// ----------------------------------------------------------------------------
`default_nettype none

package gpio_rb_pkg;

   localparam int NUM_PINS  = 54;
   localparam int PAD_BANKS = 2;

   localparam int DATA_W = 32;
   localparam int GRP_W  = 3;
   localparam int IDX_W  = 3;
   localparam int CNT_W  = IDX_W + 1;
   localparam int FSEL_W = 3;
   localparam int PULL_W = 2;
   localparam int PAD_W  = 4;

   localparam int FSEL_PER_WORD = 10;
   localparam int BIT_PER_WORD  = DATA_W;
   localparam int PULL_PER_WORD = DATA_W / PULL_W;

   localparam int FSEL_WORDS = (NUM_PINS + FSEL_PER_WORD - 1) / FSEL_PER_WORD;
   localparam int BIT_WORDS  = (NUM_PINS + BIT_PER_WORD - 1) / BIT_PER_WORD;
   localparam int PULL_WORDS = (NUM_PINS + PULL_PER_WORD - 1) / PULL_PER_WORD;

   // access codes
   localparam logic FUNC_READ  = 1'b0;
   localparam logic FUNC_WRITE = 1'b1;

   // register groups
   localparam logic [GRP_W-1:0] GRP_FSEL  = 3'd0;
   localparam logic [GRP_W-1:0] GRP_SET   = 3'd1;
   localparam logic [GRP_W-1:0] GRP_CLEAR = 3'd2;
   localparam logic [GRP_W-1:0] GRP_LEVEL = 3'd3;
   localparam logic [GRP_W-1:0] GRP_PULL  = 3'd4;
   localparam logic [GRP_W-1:0] GRP_PAD   = 3'd5;

   // function select code for output mode
   localparam logic [FSEL_W-1:0] FSEL_OUTPUT = 3'b001;

   typedef struct packed {
      logic                func;
      logic [GRP_W-1:0]    reg_group;
      logic [IDX_W-1:0]    reg_index;
      logic [DATA_W-1:0]   write_data;
      logic [NUM_PINS-1:0] pin_levels;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0]   read_data;
      logic [NUM_PINS-1:0] output_latch;
      logic [NUM_PINS-1:0] drive_enable;
      logic                access_error;
   } rsp_type;

   // number of words in a group; zero for unknown groups
   function automatic logic [CNT_W-1:0] word_count(input logic [GRP_W-1:0] grp);
      logic [CNT_W-1:0] cnt;
      case (grp)
         GRP_FSEL:                      cnt = CNT_W'(FSEL_WORDS);
         GRP_SET, GRP_CLEAR, GRP_LEVEL: cnt = CNT_W'(BIT_WORDS);
         GRP_PULL:                      cnt = CNT_W'(PULL_WORDS);
         GRP_PAD:                       cnt = CNT_W'(PAD_BANKS);
         default:                       cnt = '0;
      endcase
      return cnt;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/gpio_register_block_top.sv -----
// ----------------------------------------------------------------------------
// GPIO register block top level
// Item accept to result valid passes the input reg, then the result reg;
// decode and update are combinational logic between the two.
// Throughput: one item per cycle unless the response side stalls.
// Reset (synchronous, active high): pin registers cleared (input mode, no
// pull, latch and pad words zero); both stages emptied.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gpio_register_block_top_assert.svh"

module gpio_register_block_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   // request channel: one bus access per item
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   input  wire logic                                  req_func,
   input  wire logic [gpio_rb_pkg::GRP_W-1:0]         req_reg_group,
   input  wire logic [gpio_rb_pkg::IDX_W-1:0]         req_reg_index,
   input  wire logic [gpio_rb_pkg::DATA_W-1:0]        req_write_data,
   input  wire logic [gpio_rb_pkg::NUM_PINS-1:0]      req_pin_levels,

   // response channel: one item per request
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      logic [gpio_rb_pkg::DATA_W-1:0]        rsp_read_data,
   output      logic [gpio_rb_pkg::NUM_PINS-1:0]      rsp_output_latch,
   output      logic [gpio_rb_pkg::NUM_PINS-1:0]      rsp_drive_enable,
   output      logic                                  rsp_access_error
);
   import gpio_rb_pkg::*;

   // input stage
   logic    s1_valid_ff, s1_valid_in;
   req_type s1_req_ff, s1_req_in;

   // result stage
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic rsp_free;   // result register empty or being drained
   logic advance;    // input stage item moves into the result register
   logic req_take;   // request accepted this cycle

   always_comb begin
      rsp_free  = !rsp_valid_ff || rsp_ready;
      advance   = s1_valid_ff && rsp_free;
      req_ready = !s1_valid_ff || rsp_free;
      req_take  = req_valid && req_ready;

      // input stage refills on accept, empties when its item moves on
      s1_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_req_in   = s1_req_ff;
      if (req_take) begin
         s1_req_in.func       = req_func;
         s1_req_in.reg_group  = req_reg_group;
         s1_req_in.reg_index  = req_reg_index;
         s1_req_in.write_data = req_write_data;
         s1_req_in.pin_levels = req_pin_levels;
      end

      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   // register file: state commits at the edge the item enters the result reg
   gpio_rb_regs u_regs (
      .clock  (clock),
      .reset  (reset),
      .commit (advance),
      .req    (s1_req_ff),
      .rsp_in (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      s1_req_ff <= s1_req_in;
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_ff.read_data;
   assign rsp_output_latch = rsp_ff.output_latch;
   assign rsp_drive_enable = rsp_ff.drive_enable;
   assign rsp_access_error = rsp_ff.access_error;

   // both stages come out of reset empty
   `GRB_ASSERT_ALWAYS(a_reset_empty, clock,
      reset |=> !rsp_valid && !s1_valid_ff)
   // a blocked input stage keeps its item
   `GRB_ASSERT(a_s1_hold, clock, reset,
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_req_ff))
   // a flagged access never returns data
   `GRB_ASSERT(a_err_rdata, clock, reset,
      rsp_valid && rsp_access_error |-> rsp_read_data == '0)
   // an item leaving the input stage always lands in the result register
   `GRB_ASSERT(a_advance_lands, clock, reset,
      advance |=> rsp_valid)

endmodule

`default_nettype wire

// ----- hw/rtl/gpio_rb_regs.sv -----
// ----------------------------------------------------------------------------
// GPIO register block storage
// Pin registers, access decode and the response for one item.
// ----------------------------------------------------------------------------
`default_nettype none
`include "gpio_register_block_top_assert.svh"

module gpio_rb_regs (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                commit,
   input  wire gpio_rb_pkg::req_type req,
   output gpio_rb_pkg::rsp_type      rsp_in
);
   import gpio_rb_pkg::*;

   logic [NUM_PINS-1:0][FSEL_W-1:0] fsel_ff, fsel_in;
   logic [NUM_PINS-1:0]             output_ff, output_in;
   logic [NUM_PINS-1:0][PULL_W-1:0] pull_ff, pull_in;
   logic [PAD_BANKS-1:0][PAD_W-1:0] pad_ff, pad_in;

   logic              wr;
   logic              err;
   logic [DATA_W-1:0] rd_fsel, rd_lvl, rd_pull, rd_pad, rd_sel;
   logic [NUM_PINS-1:0] drive;

   always_comb begin
      wr  = req.func == FUNC_WRITE;
      err = {1'b0, req.reg_index} >= word_count(req.reg_group);

      fsel_in   = fsel_ff;
      output_in = output_ff;
      pull_in   = pull_ff;
      pad_in    = pad_ff;
      rd_fsel   = '0;
      rd_lvl    = '0;
      rd_pull   = '0;
      rd_pad    = '0;

      for (int p = 0; p < NUM_PINS; p++) begin
         if (req.reg_index == IDX_W'(p / FSEL_PER_WORD)) begin
            rd_fsel[FSEL_W*(p % FSEL_PER_WORD) +: FSEL_W] = fsel_ff[p];
            if (!err && wr && req.reg_group == GRP_FSEL) begin
               fsel_in[p] = req.write_data[FSEL_W*(p % FSEL_PER_WORD) +: FSEL_W];
            end
         end
         if (req.reg_index == IDX_W'(p / BIT_PER_WORD)) begin
            rd_lvl[p % BIT_PER_WORD] = req.pin_levels[p];
            if (!err && wr && req.reg_group == GRP_SET) begin
               output_in[p] = output_ff[p] | req.write_data[p % BIT_PER_WORD];
            end
            if (!err && wr && req.reg_group == GRP_CLEAR) begin
               output_in[p] = output_ff[p] & ~req.write_data[p % BIT_PER_WORD];
            end
         end
         if (req.reg_index == IDX_W'(p / PULL_PER_WORD)) begin
            rd_pull[PULL_W*(p % PULL_PER_WORD) +: PULL_W] = pull_ff[p];
            if (!err && wr && req.reg_group == GRP_PULL) begin
               pull_in[p] = req.write_data[PULL_W*(p % PULL_PER_WORD) +: PULL_W];
            end
         end
      end

      for (int b = 0; b < PAD_BANKS; b++) begin
         if (req.reg_index == IDX_W'(b)) begin
            rd_pad = DATA_W'(pad_ff[b]);
            if (!err && wr && req.reg_group == GRP_PAD) begin
               pad_in[b] = req.write_data[PAD_W-1:0];
            end
         end
      end

      case (req.reg_group)
         GRP_FSEL:  rd_sel = rd_fsel;
         GRP_LEVEL: rd_sel = rd_lvl;
         GRP_PULL:  rd_sel = rd_pull;
         GRP_PAD:   rd_sel = rd_pad;
         default:   rd_sel = '0;
      endcase

      for (int p = 0; p < NUM_PINS; p++) begin
         drive[p] = fsel_in[p] == FSEL_OUTPUT;
      end

      rsp_in.read_data    = (wr || err) ? '0 : rd_sel;
      rsp_in.output_latch = output_in;
      rsp_in.drive_enable = drive;
      rsp_in.access_error = err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsel_ff   <= '0;
         output_ff <= '0;
         pull_ff   <= '0;
         pad_ff    <= '0;
      end else if (commit) begin
         fsel_ff   <= fsel_in;
         output_ff <= output_in;
         pull_ff   <= pull_in;
         pad_ff    <= pad_in;
      end
   end

   // a rejected access leaves every register alone
   `GRB_ASSERT(a_err_no_change, clock, reset,
      !reset && commit && err |=> $stable(fsel_ff) && $stable(output_ff) && $stable(pull_ff) && $stable(pad_ff))
   // writes never return data
   `GRB_ASSERT(a_wr_rdata_zero, clock, reset,
      commit && wr |-> rsp_in.read_data == '0)
   // state only moves when an item commits
   `GRB_ASSERT(a_hold_idle, clock, reset,
      !reset && !commit |=> $stable(fsel_ff) && $stable(output_ff) && $stable(pull_ff) && $stable(pad_ff))

endmodule

`default_nettype wire

// ----- tb/gpio_register_block_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// GPIO register block testbench
// Drives bus reads and writes into every register group, with random gaps on
// the request side and random stalls on the response side. A shadow copy of
// the pin registers predicts each response; responses are checked in order.
// ----------------------------------------------------------------------------

import gpio_rb_pkg::*;

// Shadow of the pin registers plus the queue of responses still owed.
class gpio_shadow_board;
   logic [FSEL_W-1:0]   fsel_shadow [NUM_PINS];
   logic [PULL_W-1:0]   pull_shadow [NUM_PINS];
   logic [PAD_W-1:0]    pad_shadow  [PAD_BANKS];
   logic [NUM_PINS-1:0] latch_shadow;
   rsp_type             owed_rsps [$];
   int unsigned         mismatches;

   function new();
      foreach (fsel_shadow[p]) fsel_shadow[p] = '0;
      foreach (pull_shadow[p]) pull_shadow[p] = '0;
      foreach (pad_shadow[b]) pad_shadow[b] = '0;
      latch_shadow = '0;
      mismatches = 0;
   endfunction

   // words implemented in a group; zero marks an unknown group
   static function int words_in(logic [GRP_W-1:0] grp);
      case (grp)
         GRP_FSEL:                      return (NUM_PINS + 9) / 10;
         GRP_SET, GRP_CLEAR, GRP_LEVEL: return (NUM_PINS + 31) / 32;
         GRP_PULL:                      return (NUM_PINS + 15) / 16;
         GRP_PAD:                       return PAD_BANKS;
         default:                       return 0;
      endcase
   endfunction

   // apply one access to the shadow and return the response it owes
   function rsp_type apply_access(req_type a);
      rsp_type       r;
      logic [63:0]   wide;
      logic [NUM_PINS-1:0] bits;
      int            pin;
      int            idx;
      bit            wr;
      r    = '0;
      wr   = (a.func == FUNC_WRITE);
      idx  = a.reg_index;
      r.access_error = (idx >= words_in(a.reg_group));
      if (!r.access_error) begin
         case (a.reg_group)
            GRP_FSEL: begin
               for (int k = 0; k < 10; k++) begin
                  pin = idx * 10 + k;
                  if (pin < NUM_PINS) begin
                     if (wr) fsel_shadow[pin] = a.write_data[3*k +: 3];
                     else    r.read_data[3*k +: 3] = fsel_shadow[pin];
                  end
               end
            end
            GRP_SET, GRP_CLEAR: begin
               if (wr) begin
                  wide = 64'(a.write_data) << (32 * idx);
                  bits = wide[NUM_PINS-1:0];
                  if (a.reg_group == GRP_SET) latch_shadow = latch_shadow | bits;
                  else                        latch_shadow = latch_shadow & ~bits;
               end
            end
            GRP_LEVEL: begin
               if (!wr) begin
                  wide = 64'(a.pin_levels) >> (32 * idx);
                  r.read_data = wide[31:0];
               end
            end
            GRP_PULL: begin
               for (int k = 0; k < 16; k++) begin
                  pin = idx * 16 + k;
                  if (pin < NUM_PINS) begin
                     if (wr) pull_shadow[pin] = a.write_data[2*k +: 2];
                     else    r.read_data[2*k +: 2] = pull_shadow[pin];
                  end
               end
            end
            default: begin
               if (wr) pad_shadow[idx] = a.write_data[PAD_W-1:0];
               else    r.read_data = 32'(pad_shadow[idx]);
            end
         endcase
      end
      r.output_latch = latch_shadow;
      for (int p = 0; p < NUM_PINS; p++)
         r.drive_enable[p] = (fsel_shadow[p] == FSEL_OUTPUT);
      return r;
   endfunction

   function void note_access(req_type a);
      owed_rsps.push_back(apply_access(a));
   endfunction

   task report(string what);
      $display("MISMATCH at %0t: %s", $realtime, what);
      mismatches++;
   endtask

   task check_result(rsp_type got);
      rsp_type want;
      if (owed_rsps.size() == 0) begin
         report("response item with nothing owed");
         return;
      end
      want = owed_rsps.pop_front();
      if (got.read_data !== want.read_data)
         report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
      if (got.output_latch !== want.output_latch)
         report($sformatf("output_latch %h, want %h",
                          got.output_latch, want.output_latch));
      if (got.drive_enable !== want.drive_enable)
         report($sformatf("drive_enable %h, want %h",
                          got.drive_enable, want.drive_enable));
      if (got.access_error !== want.access_error)
         report($sformatf("access_error %b, want %b",
                          got.access_error, want.access_error));
   endtask
endclass

module gpio_register_block_top_test;

   localparam int RANDOM_ITEMS = 600;
   localparam logic [NUM_PINS-1:0] ALL_PINS = '1;
   // every pin in a function-select word set to output mode
   localparam logic [DATA_W-1:0] ALL_OUTPUT = 32'h0924_9249;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_func = FUNC_READ;
   logic [GRP_W-1:0]    req_reg_group = GRP_FSEL;
   logic [IDX_W-1:0]    req_reg_index = '0;
   logic [DATA_W-1:0]   req_write_data = '0;
   logic [NUM_PINS-1:0] req_pin_levels = '0;

   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [DATA_W-1:0]   rsp_read_data;
   logic [NUM_PINS-1:0] rsp_output_latch;
   logic [NUM_PINS-1:0] rsp_drive_enable;
   logic                rsp_access_error;

   gpio_shadow_board board = new();

   // items handed to the block so far; sets the idle and busy stretches
   int unsigned items_sent = 0;
   int unsigned rsps_taken = 0;

   gpio_register_block_top DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_reg_group    (req_reg_group),
      .req_reg_index    (req_reg_index),
      .req_write_data   (req_write_data),
      .req_pin_levels   (req_pin_levels),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_output_latch (rsp_output_latch),
      .rsp_drive_enable (rsp_drive_enable),
      .rsp_access_error (rsp_access_error)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watch both handshakes at the rising edge. Requests are noted before the
   // response is checked; a result is never taken at the edge its own request
   // is accepted, so the order of the two never matters within one edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_access('{req_func, req_reg_group, req_reg_index,
                                req_write_data, req_pin_levels});
         if (rsp_valid && rsp_ready)
            board.check_result('{rsp_read_data, rsp_output_latch,
                                 rsp_drive_enable, rsp_access_error});
      end
   end

   function automatic req_type access(logic f, logic [GRP_W-1:0] grp, int idx,
                                      logic [DATA_W-1:0] data,
                                      logic [NUM_PINS-1:0] levels);
      req_type a;
      a.func       = f;
      a.reg_group  = grp;
      a.reg_index  = IDX_W'(idx);
      a.write_data = data;
      a.pin_levels = levels;
      return a;
   endfunction

   function automatic logic [NUM_PINS-1:0] random_levels();
      logic [63:0] w;
      w = {$urandom(), $urandom()};
      return w[NUM_PINS-1:0];
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with valid still high, so back-to-back items need no second assignment.
   task automatic send_item(req_type a);
      int gap;
      // every third stretch of 64 items runs with no gaps at all
      gap = ((items_sent / 64) % 3 == 2) ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func       = a.func;
      req_reg_group  = a.reg_group;
      req_reg_index  = a.reg_index;
      req_write_data = a.write_data;
      req_pin_levels = a.pin_levels;
      req_valid      = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // Random accesses: mostly legal group and index, the rest anything at all.
   task automatic send_random_item();
      req_type a;
      logic [GRP_W-1:0] grp;
      int idx;
      logic [DATA_W-1:0] data;
      if ($urandom_range(0, 99) < 85) begin
         grp = GRP_W'($urandom_range(0, 5));
         idx = $urandom_range(0, board.words_in(grp) - 1);
      end else begin
         grp = GRP_W'($urandom_range(0, 7));
         idx = $urandom_range(0, 7);
      end
      data = $urandom();
      // lean function-select writes towards input/output codes so that
      // the drive enables actually move
      if (grp == GRP_FSEL && $urandom_range(0, 1) == 1)
         data = data & ALL_OUTPUT;
      a = access(logic'($urandom_range(0, 1)), grp, idx, data, random_levels());
      send_item(a);
   endtask

   // Response side: a fresh stall for every item, with stall-free stretches.
   initial begin
      int stall;
      @(negedge reset);
      @(negedge clock);
      forever begin
         stall = ((rsps_taken / 50) % 3 == 1) ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready = 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         rsps_taken++;
         @(negedge clock);
      end
   end

   initial begin
      req_type directed [$];
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset values, then the function-select word edges
      directed.push_back(access(FUNC_READ,  GRP_FSEL, 0, '0, '0));
      directed.push_back(access(FUNC_WRITE, GRP_FSEL, 0, ALL_OUTPUT, '0));
      // top word: only four pins exist, bits 31..12 never stick
      directed.push_back(access(FUNC_WRITE, GRP_FSEL, 5, '1, ALL_PINS));
      directed.push_back(access(FUNC_READ,  GRP_FSEL, 5, '0, ALL_PINS));
      directed.push_back(access(FUNC_WRITE, GRP_FSEL, 5, 32'h0000_0249, '0));
      directed.push_back(access(FUNC_READ,  GRP_FSEL, 0, '1, '0));
      // set and clear, including bits past the last pin
      directed.push_back(access(FUNC_WRITE, GRP_SET,   0, '1, '0));
      directed.push_back(access(FUNC_WRITE, GRP_SET,   1, '1, '0));
      directed.push_back(access(FUNC_WRITE, GRP_CLEAR, 1, 32'h0000_FFFF, '0));
      directed.push_back(access(FUNC_READ,  GRP_SET,   0, '0, ALL_PINS));
      directed.push_back(access(FUNC_WRITE, GRP_CLEAR, 0, 32'hAAAA_AAAA, '0));
      directed.push_back(access(FUNC_READ,  GRP_CLEAR, 1, '0, ALL_PINS));
      // level reads; a level write is quietly dropped
      directed.push_back(access(FUNC_READ,  GRP_LEVEL, 0, '0, ALL_PINS));
      directed.push_back(access(FUNC_READ,  GRP_LEVEL, 1, '0, ALL_PINS));
      directed.push_back(access(FUNC_WRITE, GRP_LEVEL, 0, '1, ALL_PINS));
      // pull code 11 on the partial top word
      directed.push_back(access(FUNC_WRITE, GRP_PULL, 3, '1, '0));
      directed.push_back(access(FUNC_READ,  GRP_PULL, 3, '0, '0));
      directed.push_back(access(FUNC_WRITE, GRP_PULL, 0, 32'hC3C3_C3C3, '0));
      directed.push_back(access(FUNC_READ,  GRP_PULL, 0, '0, '0));
      // pad words keep the low four bits only
      directed.push_back(access(FUNC_WRITE, GRP_PAD, 0, 32'hFFFF_FFF5, '0));
      directed.push_back(access(FUNC_WRITE, GRP_PAD, 1, 32'h0000_000A, '0));
      directed.push_back(access(FUNC_READ,  GRP_PAD, 0, '0, '0));
      directed.push_back(access(FUNC_READ,  GRP_PAD, 1, '0, '0));
      // unknown groups and indexes past the end: error, no change
      directed.push_back(access(FUNC_WRITE, GRP_W'(6), 0, '1, ALL_PINS));
      directed.push_back(access(FUNC_READ,  GRP_W'(7), 7, '0, ALL_PINS));
      directed.push_back(access(FUNC_WRITE, GRP_FSEL, 6, '0, '0));
      directed.push_back(access(FUNC_WRITE, GRP_SET,  2, '1, '0));
      directed.push_back(access(FUNC_READ,  GRP_PULL, 4, '0, '0));
      directed.push_back(access(FUNC_WRITE, GRP_PAD,  2, '1, '0));
      directed.push_back(access(FUNC_READ,  GRP_LEVEL, 7, '0, ALL_PINS));

      foreach (directed[i]) send_item(directed[i]);
      repeat (RANDOM_ITEMS) send_random_item();
      req_valid = 1'b0;

      // drain, then leave room for any stray response item
      while (board.owed_rsps.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);

      if (board.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // the slowest legal run ends long before this timeout
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule

// ----- gpio_register_block_top.f -----
+incdir+hw/rtl
hw/rtl/gpio_rb_pkg.sv
hw/rtl/gpio_rb_regs.sv
hw/rtl/gpio_register_block_top.sv
tb/gpio_register_block_top_test.sv
